// ----- design/deq_pkg.sv -----
// Shared operation codes, status codes and controller command type for the deque.
package deq_pkg;

  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } deq_cmd_t;

endpackage

// ----- design/deq_ctrl.sv -----
// Controller state machine: sequences capture, execution and result handoff.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output deq_pkg::deq_cmd_t cmd
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign cmd.load = s_tvalid && (state == ST_IDLE);
  assign cmd.exec = (state == ST_EXEC);

endmodule

// ----- design/deq_dp.sv -----
// Datapath: ring store, front pointer, item count and result register.
module deq_dp #(
  parameter int DEPTH = 16,
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  deq_pkg::deq_cmd_t              cmd,
  input  logic [deq_pkg::MODE_W-1:0]     in_mode,
  input  logic [deq_pkg::BYTE_W-1:0]     in_push_data,
  output logic [deq_pkg::BYTE_W-1:0]     out_data,
  output logic [deq_pkg::STATUS_W-1:0]   status,
  output logic [CW-1:0]                  fill_count
);
  import deq_pkg::*;

  logic [BYTE_W-1:0]   mem [DEPTH];
  logic [BYTE_W-1:0]   rd_q;
  logic [MODE_W-1:0]   mode;
  logic [BYTE_W-1:0]   push_data;
  logic [PW-1:0]       front;
  logic [PW-1:0]       front_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;
  logic                res_rd;
  logic                res_rd_next;
  logic                we;
  logic                re;
  logic [PW-1:0]       slot;
  logic [PW:0]         back_sum;
  logic [PW:0]         tail_sum;
  logic [PW-1:0]       back_slot;
  logic [PW-1:0]       tail_slot;
  logic [PW-1:0]       front_dec;
  logic [PW-1:0]       front_inc;
  logic                full;
  logic                empty;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign back_sum  = (PW+1)'(front) + (PW+1)'(count) - (PW+1)'(1);
  assign tail_sum  = (PW+1)'(front) + (PW+1)'(count);
  assign back_slot = (back_sum >= (PW+1)'(DEPTH)) ? PW'(back_sum - (PW+1)'(DEPTH))
                                                  : PW'(back_sum);
  assign tail_slot = (tail_sum >= (PW+1)'(DEPTH)) ? PW'(tail_sum - (PW+1)'(DEPTH))
                                                  : PW'(tail_sum);
  assign front_dec = (front == '0) ? PW'(DEPTH - 1) : front - PW'(1);
  assign front_inc = (front == PW'(DEPTH - 1)) ? '0 : front + PW'(1);

  always_comb begin
    front_next      = front;
    count_next      = count;
    res_status_next = STATUS_OK;
    res_rd_next     = 1'b0;
    we              = 1'b0;
    re              = 1'b0;
    slot            = front;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (full) begin
          res_status_next = STATUS_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
          if (mode == MODE_PUSH_FRONT) begin
            slot       = front_dec;
            front_next = front_dec;
          end else begin
            slot = tail_slot;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (empty) begin
          res_status_next = STATUS_EMPTY;
        end else begin
          re          = 1'b1;
          res_rd_next = 1'b1;
          if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
            slot = front;
          end else begin
            slot = back_slot;
          end
          if (mode == MODE_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - CW'(1);
          end else if (mode == MODE_POP_BACK) begin
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
        res_status_next = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[slot] <= push_data;
    if (cmd.exec && re) rd_q <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode      <= in_mode;
      push_data <= in_push_data;
    end
    if (cmd.exec) begin
      res_status <= res_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front  <= '0;
      count  <= '0;
      res_rd <= 1'b0;
    end else if (cmd.exec) begin
      front  <= front_next;
      count  <= count_next;
      res_rd <= res_rd_next;
    end
  end

  assign out_data   = res_rd ? rd_q : '0;
  assign status     = res_status;
  assign fill_count = count;

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the bounded double-ended byte queue.
// Usage:
//   Slave channel s_t*: one transaction per operation. s_tdata holds mode in
//   bits [2:0] (push front, push back, pop front, pop back, peek front, peek
//   back) and push_data in bits [10:3].
//   Master channel m_t*: one transaction per operation, carrying out_data,
//   status (ok, empty, full) and fill_count after the operation.
// Timing: an operation is captured in ST_IDLE, executed against the ring
//   store in ST_EXEC, and its result is presented in ST_OUT until the
//   receiver is ready. The controller holds one operation at a time: the
//   registered read of the ring store sets the execute cycle between
//   capture and result.
// Reset: rst clears the front pointer, the item count and the controller;
//   the ring store holds no reset value and is only read at live items.
// Stall: while m_tready is low the result holds on m_tdata and s_tready
//   stays low, so no new operation is taken until the result is accepted.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [15:0]                                s_tdata, // mode, push_data
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [((17 + $clog2(DEPTH + 1)) / 8) * 8 - 1:0] m_tdata // out_data, status, fill_count
);
  import deq_pkg::*;

  localparam int CW      = $clog2(DEPTH + 1);
  localparam int PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RES_W   = BYTE_W + STATUS_W + CW;
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

  deq_cmd_t            cmd;
  logic [BYTE_W-1:0]   out_data;
  logic [STATUS_W-1:0] status;
  logic [CW-1:0]       fill_count;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH),
    .PW    (PW),
    .CW    (CW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_mode      (s_tdata[MODE_W-1:0]),
    .in_push_data (s_tdata[MODE_W +: BYTE_W]),
    .out_data     (out_data),
    .status       (status),
    .fill_count   (fill_count)
  );

  assign m_tdata = TDATA_W'({fill_count, status, out_data});

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("operation taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fill_count <= CW'(DEPTH)))
    else $error("fill count exceeds depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == STATUS_FULL) |-> (fill_count == CW'(DEPTH)))
    else $error("full status without a full store");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == STATUS_EMPTY) |-> (fill_count == '0 && out_data == '0))
    else $error("empty status with items or data");

endmodule
